### sv/pngcv_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG chunk stream validator.
package pngcv_pkg;

    // Width of the byte position counter and of the reported end offset.
    localparam int OFFSET_WIDTH     = 48;
    // Number of leading signature bytes that are skipped unchecked.
    localparam int SIGNATURE_LENGTH = 8;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Walk outcome codes.
    localparam logic [1:0] ST_END    = 2'd0;
    localparam logic [1:0] ST_STOP   = 2'd1;
    localparam logic [1:0] ST_NOTPNG = 2'd2;

    // Framing phase of the front part, one-hot.
    typedef enum logic [4:0] {
        PH_SIG  = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CRC  = 5'b10000
    } t_phase;

    // Role of one byte within the chunk framing.
    typedef enum logic [2:0] {
        K_SIG      = 3'd0,
        K_LEN_HEAD = 3'd1,
        K_LEN      = 3'd2,
        K_TYPE     = 3'd3,
        K_DATA     = 3'd4,
        K_CRC      = 3'd5,
        K_CRC_LAST = 3'd6
    } t_kind;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]              data;
        logic                    last;
        t_kind                   kind;
        logic [OFFSET_WIDTH-1:0] pos;
    } t_beat;

    // One reflected CRC-32 byte step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/pngcv_front.sv
// Front part: tracks the byte position and the chunk framing and classifies each byte.
module pngcv_front import pngcv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_beat      o_beat
);

    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};
    localparam logic [OFFSET_WIDTH-1:0] SIG_END = OFFSET_WIDTH'(SIGNATURE_LENGTH);
    localparam t_phase PH_START = (SIGNATURE_LENGTH == 0) ? PH_LEN : PH_SIG;

    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    t_phase                  r_phase, n_phase;
    logic [1:0]              r_bif, n_bif;
    logic [30:0]             r_rem, n_rem;
    t_kind                   kind;

    // Framing walk for the byte at the input.
    always_comb begin
        n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        n_phase = r_phase;
        n_bif   = r_bif;
        n_rem   = r_rem;
        kind    = K_SIG;
        case (r_phase)
            PH_SIG: begin
                kind = K_SIG;
                if (n_pos >= SIG_END) n_phase = PH_LEN;
            end
            PH_LEN: begin
                kind  = (r_bif == 2'd0) ? K_LEN_HEAD : K_LEN;
                n_rem = {r_rem[22:0], i_data_byte};
                n_bif = r_bif + 2'd1;
                if (r_bif == 2'd3) n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                kind  = K_TYPE;
                n_bif = r_bif + 2'd1;
                if (r_bif == 2'd3) n_phase = (r_rem == 31'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                kind = K_DATA;
                if (r_rem != 31'd0) n_rem = r_rem - 31'd1;
                if (r_rem <= 31'd1) n_phase = PH_CRC;
            end
            PH_CRC: begin
                kind  = (r_bif == 2'd3) ? K_CRC_LAST : K_CRC;
                n_bif = r_bif + 2'd1;
                if (r_bif == 2'd3) n_phase = PH_LEN;
            end
            default: begin
                kind    = K_SIG;
                n_phase = PH_START;
            end
        endcase
    end

    assign o_beat = '{data: i_data_byte, last: i_last_byte, kind: kind, pos: n_pos};

    // State update; the last byte of a buffer starts the next buffer afresh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_pos   <= '0;
            r_phase <= PH_START;
            r_bif   <= 2'd0;
            r_rem   <= 31'd0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_rem   <= n_rem;
        end
    end

endmodule

### sv/pngcv_fifo.sv
// Short queue of classified beats between the front and the back.
module pngcv_fifo import pngcv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_beat i_beat,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_valid,
    output t_beat o_beat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_beat              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;
    logic               wr_en, rd_en;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + 1'b1;
            if (rd_en) r_rp <= r_rp + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_beat;
    end

endmodule

### sv/pngcv_back.sv
// Back part: runs the CRC, checks each chunk and produces the per-buffer result.
module pngcv_back import pngcv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_beat                   i_beat,
    output logic                    o_take,
    output logic                    empty,
    input  logic                    pop,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_saw_header,
    output logic                    o_reached_end,
    output logic [1:0]              o_walk_status
);

    localparam logic [OFFSET_WIDTH-1:0] SIG_END = OFFSET_WIDTH'(SIGNATURE_LENGTH);

    logic [31:0]             r_crc, n_crc;
    logic [31:0]             r_scrc, n_scrc;
    logic [31:0]             r_type, n_type;
    logic [OFFSET_WIDTH-1:0] r_acc, n_acc;
    logic                    r_hdr, n_hdr;
    logic                    r_iend, n_iend;
    logic                    r_done, n_done;
    logic [1:0]              r_fin, n_fin;
    logic                    r_out_vld, n_out_vld;
    logic [OFFSET_WIDTH-1:0] r_out_off, n_out_off;
    logic                    r_out_hdr, n_out_hdr;
    logic                    r_out_iend, n_out_iend;
    logic [1:0]              r_out_st, n_out_st;
    logic [1:0]              status;

    // A last beat waits only when the result register is still occupied.
    assign o_take = i_valid && (!i_beat.last || !r_out_vld || pop);

    // Chunk checking for the beat at the queue head.
    always_comb begin
        n_crc      = r_crc;
        n_scrc     = r_scrc;
        n_type     = r_type;
        n_acc      = r_acc;
        n_hdr      = r_hdr;
        n_iend     = r_iend;
        n_done     = r_done;
        n_fin      = r_fin;
        n_out_vld  = r_out_vld && !pop;
        n_out_off  = r_out_off;
        n_out_hdr  = r_out_hdr;
        n_out_iend = r_out_iend;
        n_out_st   = r_out_st;
        status     = ST_STOP;
        if (o_take) begin
            if (!r_done) begin
                case (i_beat.kind)
                    K_LEN_HEAD: begin
                        if (i_beat.data[7]) begin
                            n_done = 1'b1;
                            n_fin  = ST_STOP;
                        end
                        n_crc = CRC_INIT;
                    end
                    K_TYPE: begin
                        n_type = {r_type[23:0], i_beat.data};
                        n_crc  = crc_byte(r_crc, i_beat.data);
                    end
                    K_DATA: begin
                        n_crc = crc_byte(r_crc, i_beat.data);
                    end
                    K_CRC: begin
                        n_scrc = {r_scrc[23:0], i_beat.data};
                    end
                    K_CRC_LAST: begin
                        n_scrc = {r_scrc[23:0], i_beat.data};
                        if (~r_crc != n_scrc) begin
                            n_done = 1'b1;
                            n_fin  = ST_STOP;
                        end else if (!r_hdr && r_type != TYPE_IHDR) begin
                            n_done = 1'b1;
                            n_fin  = ST_NOTPNG;
                        end else begin
                            n_hdr  = 1'b1;
                            n_acc  = i_beat.pos;
                            n_iend = (r_type == TYPE_IEND);
                            n_crc  = CRC_INIT;
                            if (r_type == TYPE_IEND) begin
                                n_done = 1'b1;
                                n_fin  = ST_END;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // End of buffer: latch the result and return to the start state.
            if (i_beat.last) begin
                status    = n_done ? n_fin : ST_STOP;
                n_out_vld = 1'b1;
                n_out_st  = status;
                if (status == ST_NOTPNG) begin
                    n_out_off  = '0;
                    n_out_hdr  = 1'b0;
                    n_out_iend = 1'b0;
                end else begin
                    n_out_off  = n_acc;
                    n_out_hdr  = n_hdr;
                    n_out_iend = n_iend;
                end
                n_crc  = CRC_INIT;
                n_scrc = '0;
                n_type = '0;
                n_acc  = SIG_END;
                n_hdr  = 1'b0;
                n_iend = 1'b0;
                n_done = 1'b0;
                n_fin  = ST_STOP;
            end
        end
    end

    // Walk state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_scrc    <= '0;
            r_type    <= '0;
            r_acc     <= SIG_END;
            r_hdr     <= 1'b0;
            r_iend    <= 1'b0;
            r_done    <= 1'b0;
            r_fin     <= ST_STOP;
            r_out_vld <= 1'b0;
        end else begin
            r_crc     <= n_crc;
            r_scrc    <= n_scrc;
            r_type    <= n_type;
            r_acc     <= n_acc;
            r_hdr     <= n_hdr;
            r_iend    <= n_iend;
            r_done    <= n_done;
            r_fin     <= n_fin;
            r_out_vld <= n_out_vld;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_off  <= n_out_off;
        r_out_hdr  <= n_out_hdr;
        r_out_iend <= n_out_iend;
        r_out_st   <= n_out_st;
    end

    assign empty         = !r_out_vld;
    assign o_end_offset  = r_out_off;
    assign o_saw_header  = r_out_hdr;
    assign o_reached_end = r_out_iend;
    assign o_walk_status = r_out_st;

endmodule

### sv/png_chunk_stream_validator_top.sv
// Top level of the PNG chunk stream validator.
//
// Input channel: a candidate PNG buffer arrives one byte per beat on i_data_byte, with
// i_last_byte marking its final byte. A beat is taken when push is high and full is low.
// Result channel: one result per buffer, offered while empty is low and taken with pop.
// It carries the end offset of the last accepted chunk, the header-seen and end-reached
// flags and the walk status (IEND reached, stopped, not PNG).
// Throughput: one byte per cycle while full is low. The front framer classifies a byte in the
// cycle it is taken; a four-entry queue feeds the back, which does one table-free CRC-32
// byte step per cycle.
// Result path: the last byte's beat is written into the queue, then the back loads the
// result register from the queue head once that register is free.
// Stall: a held result blocks only the next buffer's last byte in the back; earlier bytes
// keep flowing until the queue fills, and then full rises.
// Reset: i_rst_n is synchronous and active low; it empties the queue and the result
// register and puts the walk at the start of the signature.
module png_chunk_stream_validator_top import pngcv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    output logic                    empty,
    input  logic                    pop,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_saw_header,
    output logic                    o_reached_end,
    output logic [1:0]              o_walk_status
);

    t_beat front_beat;
    t_beat head_beat;
    logic  head_valid;
    logic  head_take;
    logic  take;

    assign take = push && !full;

    // Framing and classification.
    pngcv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_beat      (front_beat)
    );

    // Decoupling queue.
    pngcv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take),
        .i_beat  (front_beat),
        .o_full  (full),
        .i_rd    (head_take),
        .o_valid (head_valid),
        .o_beat  (head_beat)
    );

    // CRC, chunk checks and result.
    pngcv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (head_valid),
        .i_beat        (head_beat),
        .o_take        (head_take),
        .empty         (empty),
        .pop           (pop),
        .o_end_offset  (o_end_offset),
        .o_saw_header  (o_saw_header),
        .o_reached_end (o_reached_end),
        .o_walk_status (o_walk_status)
    );

endmodule

### sv/pngcv_checker.sv
// Port-level checks for the PNG chunk stream validator, bound to the top level.
module pngcv_checker import pngcv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic [OFFSET_WIDTH-1:0] o_end_offset,
    input logic                    o_saw_header,
    input logic                    o_reached_end,
    input logic [1:0]              o_walk_status
);

    // No result is offered right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result offered right after reset");

    // A waiting result holds still until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_end_offset) && $stable(o_walk_status)))
        else $error("waiting result changed or vanished");

    // A not-PNG outcome carries all-zero fields.
    a_notpng_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_walk_status == ST_NOTPNG) |->
            (o_end_offset == '0 && !o_saw_header && !o_reached_end))
        else $error("not-PNG result with nonzero fields");

    // End flag and end status go together, and an end implies a header.
    a_end_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_reached_end == (o_walk_status == ST_END))
                    && (!o_reached_end || o_saw_header)))
        else $error("end flag and status disagree");

    // The status is always a defined outcome.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_walk_status == ST_END || o_walk_status == ST_STOP
                    || o_walk_status == ST_NOTPNG))
        else $error("undefined walk status");

endmodule

bind png_chunk_stream_validator_top pngcv_checker u_pngcv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_end_offset  (o_end_offset),
    .o_saw_header  (o_saw_header),
    .o_reached_end (o_reached_end),
    .o_walk_status (o_walk_status)
);

### bench/png_chunk_stream_validator_top_tb.sv
// Self-checking testbench for the PNG chunk stream validator: random and directed byte buffers.
module png_chunk_stream_validator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pngcv_pkg::*;

    // One walk outcome, as reported on the buffer's last byte.
    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] end_offset;
        logic                    saw_header;
        logic                    reached_end;
        logic [1:0]              walk_status;
    } t_walk_outcome;

    // Tracks the chunk walk byte by byte and holds the outcomes still owed by the block.
    class t_chunk_walk_model;
        t_walk_outcome           outcomes_due[$];
        int                      mismatches;
        logic [OFFSET_WIDTH-1:0] position;
        logic [OFFSET_WIDTH-1:0] last_good_end;
        t_phase                  phase;
        int unsigned             field_byte;
        logic [30:0]             bytes_left;
        logic [31:0]             crc;
        logic [31:0]             crc_stored;
        logic [31:0]             chunk_id;
        bit                      hdr_ok;
        bit                      iend_ok;
        bit                      stopped;
        logic [1:0]              stop_code;

        function new();
            mismatches = 0;
            restart();
        endfunction

        // Reflected CRC-32, one byte folded in bit by bit.
        static function logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c;
            for (int k = 0; k < 8; k++) begin
                r = (r >> 1) ^ ({32{r[0] ^ b[k]}} & 32'hEDB8_8320);
            end
            return r;
        endfunction

        // State at the start of a buffer.
        function void restart();
            position      = '0;
            last_good_end = OFFSET_WIDTH'(SIGNATURE_LENGTH);
            if (SIGNATURE_LENGTH == 0) begin
                phase = PH_LEN;
            end else begin
                phase = PH_SIG;
            end
            field_byte = 0;
            bytes_left = '0;
            crc        = CRC_INIT;
            crc_stored = '0;
            chunk_id   = '0;
            hdr_ok     = 0;
            iend_ok    = 0;
            stopped    = 0;
            stop_code  = ST_STOP;
        endfunction

        // Advance the walk by one accepted beat; on the last byte queue the outcome.
        function void take_byte(logic [7:0] b, logic is_last);
            t_walk_outcome o;
            if (position != '1) begin
                position = position + 1'b1;
            end
            if (!stopped) begin
                case (phase)
                    PH_SIG: begin
                        if (position >= SIGNATURE_LENGTH) begin
                            phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        // A set top bit in the first length byte means a length above the limit.
                        if (field_byte == 0 && b[7]) begin
                            stopped   = 1;
                            stop_code = ST_STOP;
                        end else begin
                            bytes_left = {bytes_left[22:0], b};
                            field_byte++;
                            if (field_byte >= 4) begin
                                field_byte = 0;
                                crc        = CRC_INIT;
                                phase      = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        chunk_id = {chunk_id[23:0], b};
                        crc      = crc_feed(crc, b);
                        field_byte++;
                        if (field_byte >= 4) begin
                            field_byte = 0;
                            if (bytes_left == 0) begin
                                phase = PH_CRC;
                            end else begin
                                phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        crc = crc_feed(crc, b);
                        if (bytes_left != 0) begin
                            bytes_left = bytes_left - 1'b1;
                        end
                        if (bytes_left == 0) begin
                            phase = PH_CRC;
                        end
                    end
                    default: begin
                        crc_stored = {crc_stored[23:0], b};
                        field_byte++;
                        if (field_byte >= 4) begin
                            field_byte = 0;
                            // Chunk complete: CRC first, then the first-chunk rule, then IEND.
                            if ((crc ^ CRC_INIT) != crc_stored) begin
                                stopped   = 1;
                                stop_code = ST_STOP;
                            end else if (!hdr_ok && chunk_id != TYPE_IHDR) begin
                                stopped   = 1;
                                stop_code = ST_NOTPNG;
                            end else begin
                                hdr_ok        = 1;
                                last_good_end = position;
                                iend_ok       = (chunk_id == TYPE_IEND);
                                if (iend_ok) begin
                                    stopped   = 1;
                                    stop_code = ST_END;
                                end else begin
                                    crc   = CRC_INIT;
                                    phase = PH_LEN;
                                end
                            end
                        end
                    end
                endcase
            end
            if (is_last) begin
                o.walk_status = stopped ? stop_code : ST_STOP;
                if (o.walk_status == ST_NOTPNG) begin
                    o.end_offset  = '0;
                    o.saw_header  = 0;
                    o.reached_end = 0;
                end else begin
                    o.end_offset  = last_good_end;
                    o.saw_header  = hdr_ok;
                    o.reached_end = iend_ok;
                end
                outcomes_due.push_back(o);
                restart();
            end
        endfunction

        // Compare one accepted result beat with the oldest outcome owed.
        function void check_result(logic [OFFSET_WIDTH-1:0] off, logic hdr, logic iend,
                                   logic [1:0] st);
            t_walk_outcome want;
            if (outcomes_due.size() == 0) begin
                $error("result beat with no buffer outstanding: end_offset %0h status %0d",
                       off, st);
                mismatches++;
                return;
            end
            want = outcomes_due.pop_front();
            if (want.end_offset !== off) begin
                $error("end_offset: expected %0h, got %0h", want.end_offset, off);
                mismatches++;
            end
            if (want.saw_header !== hdr) begin
                $error("saw_header: expected %0b, got %0b", want.saw_header, hdr);
                mismatches++;
            end
            if (want.reached_end !== iend) begin
                $error("reached_end: expected %0b, got %0b", want.reached_end, iend);
                mismatches++;
            end
            if (want.walk_status !== st) begin
                $error("walk_status: expected %0d, got %0d", want.walk_status, st);
                mismatches++;
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              i_data_byte;
    logic                    i_last_byte;
    logic                    empty;
    logic                    pop;
    logic [OFFSET_WIDTH-1:0] o_end_offset;
    logic                    o_saw_header;
    logic                    o_reached_end;
    logic [1:0]              o_walk_status;

    t_chunk_walk_model walk_model;
    logic [7:0]        png_bytes[$];
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_left;
    int                bytes_sent;

    png_chunk_stream_validator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .empty         (empty),
        .pop           (pop),
        .o_end_offset  (o_end_offset),
        .o_saw_header  (o_saw_header),
        .o_reached_end (o_reached_end),
        .o_walk_status (o_walk_status)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Append a 32-bit word, most significant byte first.
    function automatic void put_be32(logic [31:0] v);
        for (int k = 3; k >= 0; k--) begin
            png_bytes.push_back(v[8*k +: 8]);
        end
    endfunction

    // Leading signature: the real one half of the time, random bytes otherwise.
    function automatic void put_signature();
        logic [63:0] sig;
        bit          genuine;
        sig     = 64'h8950_4E47_0D0A_1A0A;
        genuine = 1'($urandom_range(1, 0));
        for (int i = 0; i < SIGNATURE_LENGTH; i++) begin
            if (genuine && i < 8) begin
                png_bytes.push_back(sig[8*(7-i) +: 8]);
            end else begin
                png_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    // Append a chunk with random data and a correct, or deliberately broken, CRC.
    function automatic void add_chunk(logic [31:0] ctype, int unsigned dlen, bit bad_crc);
        logic [31:0] c;
        logic [7:0]  d;
        put_be32(dlen);
        c = CRC_INIT;
        for (int k = 3; k >= 0; k--) begin
            png_bytes.push_back(ctype[8*k +: 8]);
            c = t_chunk_walk_model::crc_feed(c, ctype[8*k +: 8]);
        end
        for (int unsigned i = 0; i < dlen; i++) begin
            d = 8'($urandom);
            png_bytes.push_back(d);
            c = t_chunk_walk_model::crc_feed(c, d);
        end
        c = ~c;
        if (bad_crc) begin
            c = c ^ (32'h1 << $urandom_range(31, 0));
        end
        put_be32(c);
    endfunction

    // Mostly well-formed chunk streams, with faults, truncation and plain noise mixed in.
    function automatic void make_buffer();
        int          pick;
        int          cut;
        logic [31:0] first_type;
        png_bytes.delete();
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            repeat ($urandom_range(40, 1)) png_bytes.push_back(8'($urandom));
            return;
        end
        put_signature();
        pick = $urandom_range(99, 0);
        if (pick < 88) begin
            first_type = TYPE_IHDR;
        end else if (pick < 94) begin
            first_type = TYPE_IEND;
        end else begin
            first_type = $urandom;
        end
        add_chunk(first_type, ($urandom_range(9, 0) < 7) ? 13 : $urandom_range(5, 0),
                  $urandom_range(99, 0) < 6);
        repeat ($urandom_range(3, 0)) begin
            add_chunk(($urandom_range(99, 0) < 15) ? TYPE_IHDR : $urandom,
                      $urandom_range(10, 0), $urandom_range(99, 0) < 6);
        end
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
            // Length word with its top bit set.
            png_bytes.push_back(8'h80 | 8'($urandom));
            repeat (3) png_bytes.push_back(8'($urandom));
        end else if (pick < 10) begin
            // Huge but legal length; the buffer runs out inside the data.
            put_be32((pick < 7) ? 32'h7FFF_FFFF : ($urandom & 32'h7FFF_FFFF));
            put_be32($urandom);
            repeat ($urandom_range(6, 0)) png_bytes.push_back(8'($urandom));
        end else if (pick < 65) begin
            add_chunk(TYPE_IEND, ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : 0,
                      $urandom_range(99, 0) < 4);
        end
        repeat ($urandom_range(4, 0)) png_bytes.push_back(8'($urandom));
        if ($urandom_range(99, 0) < 20) begin
            cut = $urandom_range(png_bytes.size(), 1);
            while (png_bytes.size() > cut) begin
                png_bytes.pop_back();
            end
        end
    endfunction

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        walk_model.take_byte(b, is_last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < png_bytes.size(); i++) begin
            send_byte(png_bytes[i], i == png_bytes.size() - 1);
        end
    endtask

    // Result side: random pop stalls, plus a long hold-off counted here when requested.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                walk_model.check_result(o_end_offset, o_saw_header, o_reached_end,
                                        o_walk_status);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        walk_model    = new();
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_data_byte   = 8'h00;
        i_last_byte   = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 52;
        hold_left     = 0;
        bytes_sent    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Buffer that ends inside the signature.
        png_bytes = {8'hFF};
        send_buffer();
        // First length byte above the limit.
        png_bytes.delete();
        put_signature();
        png_bytes.push_back(8'hFF);
        send_buffer();
        // Empty IHDR, buffer ends exactly at the chunk boundary.
        png_bytes.delete();
        put_signature();
        add_chunk(TYPE_IHDR, 0, 0);
        send_buffer();

        for (int n = 0; n < 30 || bytes_sent < 2000; n++) begin
            if (n == 10) begin
                // Swap the idle rates after the sender has let everything drain.
                push <= 1'b0;
                @(negedge i_clk);
                while (walk_model.pending() != 0) begin
                    @(negedge i_clk);
                end
                send_idle_pct = 52;
                recv_idle_pct = 33;
            end
            if (n == 20) begin
                // Full rate, starting with a long result hold-off so the input backs up.
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_left     = 400;
            end
            make_buffer();
            send_buffer();
        end

        push <= 1'b0;
        @(negedge i_clk);
        while (walk_model.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (walk_model.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/pngcv_pkg.sv
sv/pngcv_front.sv
sv/pngcv_fifo.sv
sv/pngcv_back.sv
sv/png_chunk_stream_validator_top.sv
sv/pngcv_checker.sv
bench/png_chunk_stream_validator_top_tb.sv
